[sv/tscp_pkg.sv]
// Shared types and constants for the texture slot cache policy block.
`timescale 1ns / 1ps
`default_nettype none
package tscp_pkg;

  localparam int unsigned TAG_W       = 32;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned SLOTS_RESET = 32;
  localparam int unsigned IN_DATA_W   = 40;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 8;
  localparam int unsigned OUT_USER_W  = 3;
  localparam int unsigned OUT_IDX_W   = 5;

  typedef enum logic [1:0] {
    FUNC_LOOKUP      = 2'd0,
    FUNC_BEGIN_FRAME = 2'd1,
    FUNC_END_FRAME   = 2'd2,
    FUNC_BEGIN_SESS  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_LOADED  = 3'd1,
    ST_EVICTED = 3'd2,
    ST_DELAYED = 3'd3,
    ST_EVENT   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic have_free;
  } scan_flags_t;

endpackage
`default_nettype wire

[sv/tscp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tscp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_W-1:0]     wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic [ADDR_W-1:0]     rd_addr,
  output logic      [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

[sv/tscp_scan_unit.sv]
// Slot scan engine: one tag compare and one hit-count compare per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tscp_scan_unit #(
  parameter int unsigned SLOT_COUNT     = 32,
  parameter int unsigned HIT_COUNT_BITS = 16,
  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int unsigned N_W   = ($clog2(SLOT_COUNT + 1) > tscp_pkg::CFG_W) ?
                                  $clog2(SLOT_COUNT + 1) : tscp_pkg::CFG_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [N_W-1:0]               n,
  input  wire logic [tscp_pkg::TAG_W-1:0]   id,
  input  wire logic [SLOT_COUNT-1:0]        valid_vec,
  input  wire logic [SLOT_COUNT-1:0]        flush_vec,
  input  wire logic [tscp_pkg::TAG_W-1:0]   tag_rd,
  input  wire logic [HIT_COUNT_BITS-1:0]    cnt_rd,
  output logic      [IDX_W-1:0]             rd_addr,
  output tscp_pkg::scan_flags_t             flags,
  output logic      [IDX_W-1:0]             hit_idx,
  output logic      [HIT_COUNT_BITS-1:0]    hit_cnt,
  output logic      [IDX_W-1:0]             free_idx,
  output logic      [IDX_W-1:0]             min_idx
);

  logic                      run_r, run_nxt;
  logic                      done_r, done_nxt;
  logic                      hit_r, hit_nxt;
  logic                      free_r, free_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]          hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]          free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]          min_idx_r, min_idx_nxt;
  logic [HIT_COUNT_BITS-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [HIT_COUNT_BITS-1:0] min_cnt_r, min_cnt_nxt;
  logic [HIT_COUNT_BITS-1:0] cnt_eff;
  logic                      match;
  logic                      last;

  always_comb begin
    cnt_eff = valid_vec[cmp_idx_r] ? cnt_rd : '0;
    match   = valid_vec[cmp_idx_r] && (tag_rd == id);
    last    = ((N_W'(cmp_idx_r) + N_W'(1)) == n);

    run_nxt      = run_r;
    done_nxt     = done_r;
    hit_nxt      = hit_r;
    free_nxt     = free_r;
    cmp_vld_nxt  = cmp_vld_r;
    rd_idx_nxt   = rd_idx_r;
    cmp_idx_nxt  = cmp_idx_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    min_idx_nxt  = min_idx_r;
    hit_cnt_nxt  = hit_cnt_r;
    min_cnt_nxt  = min_cnt_r;

    if (start) begin
      run_nxt     = 1'b1;
      done_nxt    = 1'b0;
      hit_nxt     = 1'b0;
      free_nxt    = 1'b0;
      cmp_vld_nxt = 1'b0;
      rd_idx_nxt  = '0;
    end else if (run_r) begin
      cmp_vld_nxt = 1'b1;
      cmp_idx_nxt = rd_idx_r;
      if ((N_W'(rd_idx_r) + N_W'(1)) < n) begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
      if (cmp_vld_r) begin
        if (match) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          hit_cnt_nxt = cnt_rd;
          run_nxt     = 1'b0;
          done_nxt    = 1'b1;
        end else begin
          if (flush_vec[cmp_idx_r]) begin
            free_nxt     = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if ((cmp_idx_r == '0) || (cnt_eff < min_cnt_r)) begin
            min_cnt_nxt = cnt_eff;
            min_idx_nxt = cmp_idx_r;
          end
          if (last) begin
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      done_r    <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      cmp_vld_r <= 1'b0;
      rd_idx_r  <= '0;
      cmp_idx_r <= '0;
    end else begin
      run_r     <= run_nxt;
      done_r    <= done_nxt;
      hit_r     <= hit_nxt;
      free_r    <= free_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      rd_idx_r  <= rd_idx_nxt;
      cmp_idx_r <= cmp_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    min_idx_r  <= min_idx_nxt;
    hit_cnt_r  <= hit_cnt_nxt;
    min_cnt_r  <= min_cnt_nxt;
  end

  assign rd_addr         = rd_idx_r;
  assign flags.done      = done_r;
  assign flags.hit       = hit_r;
  assign flags.have_free = free_r;
  assign hit_idx         = hit_idx_r;
  assign hit_cnt         = hit_cnt_r;
  assign free_idx        = free_idx_r;
  assign min_idx         = min_idx_r;

endmodule
`default_nettype wire

[sv/texture_slot_cache_policy.sv]
// Top level of the texture slot cache policy: sequencer, slot flags and result register.
//
// Usage:
//   in_*  : one request per item. in_tuser = func (lookup, begin frame, end frame,
//           begin session). in_tdata = texture_id, force_load, scene_open.
//   out_* : one result per request. out_tuser = status, out_tdata = slot_index,
//           flush_needed.
//   cfg_* : cfg_wr_en writes slots_in_use; write only while no request is pending.
// Scan: a lookup that scans stops at the slot that hits, or after all n slots in use
//   when it misses; the scan reads one slot of the tag and hit-count RAMs per cycle
//   and compares it in the shared scan unit. Frame and session events, and lookups
//   that are delayed without a scan, go straight from accept to the update step.
// Throughput: one item at a time; in_tready is high only while no item is in work.
// Reset: rst_n (synchronous) invalidates all slots, flush-marks them, clears used
//   marks and sets slots_in_use to 32. No clearing pass is needed.
// Stall: a held result sits in the output register; the next item is still taken,
//   and its result waits in the update step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
module texture_slot_cache_policy #(
  parameter int unsigned SLOT_COUNT     = 32,
  parameter int unsigned HIT_COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [tscp_pkg::CFG_W-1:0]        cfg_wr_data,    // slots_in_use
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [31:0] texture_id, [32] force_load, [33] scene_open, [39:34] zero
  input  wire logic [tscp_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] func
  input  wire logic [tscp_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [4:0] slot_index, [5] flush_needed, [7:6] zero
  output logic      [tscp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [2:0] status
  output logic      [tscp_pkg::OUT_USER_W-1:0]   out_tuser
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned N_W   = ($clog2(SLOT_COUNT + 1) > tscp_pkg::CFG_W) ?
                                  $clog2(SLOT_COUNT + 1) : tscp_pkg::CFG_W;
  localparam int unsigned XW    = (IDX_W > tscp_pkg::OUT_IDX_W) ? IDX_W :
                                  tscp_pkg::OUT_IDX_W;

  tscp_pkg::state_t             state_r, state_nxt;
  tscp_pkg::func_t              func_r;
  logic [tscp_pkg::TAG_W-1:0]   id_r;
  logic                         force_r;
  logic                         go_r;
  logic [tscp_pkg::CFG_W-1:0]   slots_r;
  logic [SLOT_COUNT-1:0]        valid_r, valid_nxt;
  logic [SLOT_COUNT-1:0]        flush_r, flush_nxt;
  logic [SLOT_COUNT-1:0]        used_r, used_nxt;
  logic [SLOT_COUNT-1:0]        mask;
  logic                         out_tvalid_r, out_tvalid_nxt;
  tscp_pkg::status_t            out_status_r, status_nxt;
  logic [tscp_pkg::OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                         out_flush_r, flush_flag_nxt;
  logic [N_W-1:0]               n;
  logic                         in_acc;
  logic                         in_go;
  logic                         upd_fire;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             free_idx;
  logic [IDX_W-1:0]             min_idx;
  logic [HIT_COUNT_BITS-1:0]    hit_cnt;
  tscp_pkg::scan_flags_t        flags;
  logic [tscp_pkg::TAG_W-1:0]   tag_rd;
  logic [HIT_COUNT_BITS-1:0]    cnt_rd;
  logic                         tag_we;
  logic                         cnt_we;
  logic [IDX_W-1:0]             wr_addr;
  logic [HIT_COUNT_BITS-1:0]    cnt_wdata;
  logic [XW-1:0]                idx_ext;

  always_comb begin
    if (N_W'(slots_r) > N_W'(SLOT_COUNT)) begin
      n = N_W'(SLOT_COUNT);
    end else begin
      n = N_W'(slots_r);
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      mask[i] = (N_W'(i) < n);
    end
  end

  assign in_tready = (state_r == tscp_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_go     = (tscp_pkg::func_t'(in_tuser) == tscp_pkg::FUNC_LOOKUP) &&
                     in_tdata[33] && (n != '0);
  assign upd_fire  = (state_r == tscp_pkg::S_UPDATE) && (!out_tvalid_r || out_tready);

  tscp_scan_unit #(
    .SLOT_COUNT     (SLOT_COUNT),
    .HIT_COUNT_BITS (HIT_COUNT_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && in_go),
    .n         (n),
    .id        (id_r),
    .valid_vec (valid_r),
    .flush_vec (flush_r),
    .tag_rd    (tag_rd),
    .cnt_rd    (cnt_rd),
    .rd_addr   (rd_addr),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .hit_cnt   (hit_cnt),
    .free_idx  (free_idx),
    .min_idx   (min_idx)
  );

  tscp_ram #(
    .WIDTH (tscp_pkg::TAG_W),
    .DEPTH (SLOT_COUNT)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (wr_addr),
    .wr_data (id_r),
    .rd_addr (rd_addr),
    .rd_data (tag_rd)
  );

  tscp_ram #(
    .WIDTH (HIT_COUNT_BITS),
    .DEPTH (SLOT_COUNT)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (wr_addr),
    .wr_data (cnt_wdata),
    .rd_addr (rd_addr),
    .rd_data (cnt_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    flush_nxt      = flush_r;
    used_nxt       = used_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    status_nxt     = tscp_pkg::ST_EVENT;
    wr_addr        = hit_idx;
    flush_flag_nxt = 1'b0;
    tag_we         = 1'b0;
    cnt_we         = 1'b0;
    cnt_wdata      = HIT_COUNT_BITS'(1);

    unique case (state_r)
      tscp_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_go ? tscp_pkg::S_SCAN : tscp_pkg::S_UPDATE;
        end
      end
      tscp_pkg::S_SCAN: begin
        if (flags.done) begin
          state_nxt = tscp_pkg::S_UPDATE;
        end
      end
      tscp_pkg::S_UPDATE: begin
        if (upd_fire) begin
          state_nxt      = tscp_pkg::S_IDLE;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = tscp_pkg::S_IDLE;
      end
    endcase

    unique case (func_r)
      tscp_pkg::FUNC_LOOKUP: begin
        status_nxt = tscp_pkg::ST_DELAYED;
        if (go_r) begin
          if (flags.hit) begin
            status_nxt = tscp_pkg::ST_HIT;
            wr_addr    = hit_idx;
            cnt_we     = 1'b1;
            cnt_wdata  = (hit_cnt == '1) ? hit_cnt : hit_cnt + HIT_COUNT_BITS'(1);
          end else if (flags.have_free) begin
            status_nxt = tscp_pkg::ST_LOADED;
            wr_addr    = free_idx;
            tag_we     = 1'b1;
            cnt_we     = 1'b1;
          end else if (force_r) begin
            status_nxt     = tscp_pkg::ST_EVICTED;
            wr_addr        = min_idx;
            tag_we         = 1'b1;
            cnt_we         = 1'b1;
            flush_flag_nxt = 1'b1;
          end
        end
        if (cnt_we) begin
          flush_nxt[wr_addr] = 1'b0;
          used_nxt[wr_addr]  = 1'b1;
        end
        if (tag_we) begin
          valid_nxt[wr_addr] = 1'b1;
        end
      end
      tscp_pkg::FUNC_BEGIN_FRAME: begin
        used_nxt = used_r & ~mask;
      end
      tscp_pkg::FUNC_END_FRAME: begin
        flush_nxt = flush_r | (~used_r & mask);
      end
      tscp_pkg::FUNC_BEGIN_SESS: begin
        flush_nxt = flush_r | mask;
        used_nxt  = used_r & ~mask;
        valid_nxt = valid_r & ~mask;
      end
      default: begin
        status_nxt = tscp_pkg::ST_EVENT;
      end
    endcase

    if (!upd_fire) begin
      valid_nxt = valid_r;
      flush_nxt = flush_r;
      used_nxt  = used_r;
      tag_we    = 1'b0;
      cnt_we    = 1'b0;
    end

    idx_ext = XW'(wr_addr);
    if ((status_nxt == tscp_pkg::ST_DELAYED) || (status_nxt == tscp_pkg::ST_EVENT)) begin
      idx_ext = '0;
    end
    out_idx_nxt = idx_ext[tscp_pkg::OUT_IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tscp_pkg::S_IDLE;
      slots_r      <= tscp_pkg::CFG_W'(tscp_pkg::SLOTS_RESET);
      valid_r      <= '0;
      flush_r      <= '1;
      used_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      flush_r      <= flush_nxt;
      used_r       <= used_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        slots_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= tscp_pkg::func_t'(in_tuser);
      id_r    <= in_tdata[31:0];
      force_r <= in_tdata[32];
      go_r    <= in_go;
    end
    if (upd_fire) begin
      out_status_r <= status_nxt;
      out_idx_r    <= out_idx_nxt;
      out_flush_r  <= flush_flag_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_flush_r, out_idx_r};

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tscp_pkg::S_SCAN && flags.done && flags.hit) |-> valid_r[hit_idx])
    else $error("scan hit on an invalid slot");

  a_free_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tscp_pkg::S_SCAN && flags.done && !flags.hit && flags.have_free)
      |-> flush_r[free_idx])
    else $error("free slot is not flush-marked");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> (cnt_wdata != '0))
    else $error("hit count written as zero");

  a_go_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_go) |=> (state_r == tscp_pkg::S_SCAN))
    else $error("scanning lookup did not enter scan");

  a_flush_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_flush_r) |-> (out_status_r == tscp_pkg::ST_EVICTED))
    else $error("flush flagged without eviction");

endmodule
`default_nettype wire

[tb/tb_texture_slot_cache_policy.sv]
// Testbench for the texture slot cache policy: directed and random requests checked by a predictor.
`timescale 1ns / 1ps
module tb_texture_slot_cache_policy;

  localparam int SLOTS           = 32;
  localparam int HIT_BITS        = 16;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HEAVY_HITS      = 20;
  localparam int POOL_MAX        = 48;

  typedef struct {
    tscp_pkg::func_t func;
    logic [31:0]     texture_id;
    logic            force_load;
    logic            scene_open;
  } request_t;

  typedef struct {
    tscp_pkg::status_t status;
    logic [4:0]        slot_index;
    logic              flush_needed;
  } outcome_t;

  class slot_policy_tracker;
    logic [tscp_pkg::TAG_W-1:0] tag [SLOTS];
    bit                         valid [SLOTS];
    bit                         flush_mark [SLOTS];
    bit                         used_mark [SLOTS];
    bit [HIT_BITS-1:0]          hit_count [SLOTS];
    bit [tscp_pkg::CFG_W-1:0]   slots_in_use;
    outcome_t                   awaited_outcomes [$];
    int                         mismatches;
    int                         requests;
    int                         status_seen [5];

    function new();
      int s;
      for (s = 0; s < SLOTS; s++) begin
        tag[s]        = '0;
        valid[s]      = 1'b0;
        flush_mark[s] = 1'b1;
        used_mark[s]  = 1'b0;
        hit_count[s]  = '0;
      end
      for (s = 0; s < 5; s++) status_seen[s] = 0;
      slots_in_use = tscp_pkg::CFG_W'(tscp_pkg::SLOTS_RESET);
      mismatches   = 0;
      requests     = 0;
    endfunction

    function void load_slot(int s, logic [tscp_pkg::TAG_W-1:0] id);
      tag[s]        = id;
      valid[s]      = 1'b1;
      flush_mark[s] = 1'b0;
      used_mark[s]  = 1'b1;
      hit_count[s]  = HIT_BITS'(1);
    endfunction

    function outcome_t predict_outcome(request_t r);
      outcome_t o;
      int       n;
      int       i;
      int       at;
      int       free_slot;
      int       least;
      bit       hit;
      bit       have_free;
      o.status       = tscp_pkg::ST_EVENT;
      o.slot_index   = '0;
      o.flush_needed = 1'b0;
      n = (slots_in_use > SLOTS) ? SLOTS : int'(slots_in_use);
      case (r.func)
        tscp_pkg::FUNC_LOOKUP: begin
          o.status = tscp_pkg::ST_DELAYED;
          if (r.scene_open && n > 0) begin
            hit       = 1'b0;
            have_free = 1'b0;
            free_slot = 0;
            at        = 0;
            for (i = 0; i < n; i++) begin
              if (valid[i] && tag[i] == r.texture_id) begin
                hit = 1'b1;
                at  = i;
                break;
              end
              if (flush_mark[i]) begin
                have_free = 1'b1;
                free_slot = i;
              end
            end
            if (hit) begin
              flush_mark[at] = 1'b0;
              used_mark[at]  = 1'b1;
              if (hit_count[at] != {HIT_BITS{1'b1}}) hit_count[at]++;
              o.status     = tscp_pkg::ST_HIT;
              o.slot_index = at[4:0];
            end else if (have_free) begin
              load_slot(free_slot, r.texture_id);
              o.status     = tscp_pkg::ST_LOADED;
              o.slot_index = free_slot[4:0];
            end else if (r.force_load) begin
              least = 0;
              for (i = 1; i < n; i++)
                if (hit_count[i] < hit_count[least]) least = i;
              load_slot(least, r.texture_id);
              o.status       = tscp_pkg::ST_EVICTED;
              o.slot_index   = least[4:0];
              o.flush_needed = 1'b1;
            end
          end
        end
        tscp_pkg::FUNC_BEGIN_FRAME: begin
          for (i = 0; i < n; i++) used_mark[i] = 1'b0;
        end
        tscp_pkg::FUNC_END_FRAME: begin
          for (i = 0; i < n; i++)
            if (!used_mark[i]) flush_mark[i] = 1'b1;
        end
        default: begin
          for (i = 0; i < n; i++) begin
            flush_mark[i] = 1'b1;
            used_mark[i]  = 1'b0;
            hit_count[i]  = '0;
            valid[i]      = 1'b0;
          end
        end
      endcase
      return o;
    endfunction

    function void take_request(request_t r);
      awaited_outcomes.push_back(predict_outcome(r));
      requests++;
    endfunction

    task report(string what);
      $display("MISMATCH: %s", what);
      mismatches++;
    endtask

    task check_result(logic [2:0] status, logic [4:0] slot_index, logic flush_needed);
      outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        report($sformatf("result with none pending: status=%0d slot=%0d flush=%b",
                         status, slot_index, flush_needed));
        return;
      end
      want = awaited_outcomes.pop_front();
      if (status !== want.status || slot_index !== want.slot_index ||
          flush_needed !== want.flush_needed)
        report($sformatf("got status=%0d slot=%0d flush=%b, want status=%0d slot=%0d flush=%b",
                         status, slot_index, flush_needed,
                         want.status, want.slot_index, want.flush_needed));
      else
        status_seen[int'(want.status)]++;
    endtask
  endclass

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            cfg_wr_en   = 1'b0;
  logic [tscp_pkg::CFG_W-1:0]      cfg_wr_data = '0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [tscp_pkg::IN_DATA_W-1:0]  in_tdata    = '0;
  logic [tscp_pkg::IN_USER_W-1:0]  in_tuser    = '0;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic [tscp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [tscp_pkg::OUT_USER_W-1:0] out_tuser;

  slot_policy_tracker tracker = new();

  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          hold_request  = 0;
  int          hold_left     = 0;
  int          pool_size     = 2;
  logic [31:0] id_pool [POOL_MAX];

  texture_slot_cache_policy dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(out_tuser, out_tdata[tscp_pkg::OUT_IDX_W-1:0],
                           out_tdata[tscp_pkg::OUT_IDX_W]);
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= out_stall_pct);
    end
  end

  function automatic request_t make_request(tscp_pkg::func_t f, logic [31:0] id,
                                            logic force_load, logic scene_open);
    request_t r;
    r.func       = f;
    r.texture_id = id;
    r.force_load = force_load;
    r.scene_open = scene_open;
    return r;
  endfunction

  task automatic send_request(input request_t r);
    while (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.func;
    in_tdata  <= {{(tscp_pkg::IN_DATA_W-34){1'b0}}, r.scene_open, r.force_load,
                  r.texture_id};
    do begin
      @(posedge clk);
    end while (!in_tready);
    tracker.take_request(r);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slots(input logic [tscp_pkg::CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.slots_in_use = value;
  endtask

  function automatic request_t pool_lookup();
    logic [31:0] id;
    if ($urandom_range(9, 0) == 0) id = $urandom;
    else id = id_pool[$urandom_range(pool_size - 1, 0)];
    return make_request(tscp_pkg::FUNC_LOOKUP, id, 1'($urandom_range(1, 0)),
                        $urandom_range(19, 0) != 0);
  endfunction

  task automatic random_traffic(input int count);
    int              sent;
    int              pick;
    tscp_pkg::func_t opener;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99, 0);
      if (pick < 6) opener = tscp_pkg::FUNC_BEGIN_SESS;
      else if (pick < 12) opener = tscp_pkg::FUNC_END_FRAME;
      else opener = tscp_pkg::FUNC_BEGIN_FRAME;
      send_request(make_request(opener, $urandom, 1'($urandom_range(1, 0)),
                                1'($urandom_range(1, 0))));
      sent++;
      repeat ($urandom_range(12, 1)) begin
        send_request(pool_lookup());
        sent++;
      end
      if ($urandom_range(9, 0) != 0) begin
        send_request(make_request(tscp_pkg::FUNC_END_FRAME, $urandom,
                                  1'($urandom_range(1, 0)), 1'($urandom_range(1, 0))));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [tscp_pkg::CFG_W-1:0] slots, input int in_pct,
                           input int out_pct, input int count);
    int n;
    int k;
    settle();
    write_slots(slots);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    n = (slots > SLOTS) ? SLOTS : int'(slots);
    pool_size = n + n / 2 + 2;
    if (pool_size > POOL_MAX) pool_size = POOL_MAX;
    for (k = 0; k < pool_size; k++) id_pool[k] = $urandom;
    random_traffic(count);
  endtask

  // Pile hits onto one slot, then force an eviction that must pick the other, less-hit slot.
  task automatic skew_hit_counts();
    logic [31:0] base;
    settle();
    write_slots(6'd2);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    base = $urandom;
    send_request(make_request(tscp_pkg::FUNC_BEGIN_SESS, base, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, base, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, base ^ 32'd1, 1'b0, 1'b1));
    repeat (HEAVY_HITS)
      send_request(make_request(tscp_pkg::FUNC_LOOKUP, base ^ 32'd1,
                                1'($urandom_range(1, 0)), 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, base ^ 32'd2, 1'b1, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, base ^ 32'd1, 1'b0, 1'b1));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b1, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_BEGIN_FRAME, 32'hA5A5_A5A5, 1'b1, 1'b0));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_END_FRAME, 32'h5A5A_5A5A, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h1234_5678, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_BEGIN_SESS, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b0, 1'b1));

    settle();
    write_slots(6'd2);
    send_request(make_request(tscp_pkg::FUNC_BEGIN_SESS, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'hAAAA_AAAA, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h5555_5555, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h0F0F_0F0F, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h5555_5555, 1'b0, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h0F0F_0F0F, 1'b1, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'hF0F0_F0F0, 1'b1, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_END_FRAME, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_request(tscp_pkg::FUNC_BEGIN_FRAME, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_request(tscp_pkg::FUNC_END_FRAME, 32'h0000_0000, 1'b0, 1'b0));
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h5555_5555, 1'b0, 1'b1));

    settle();
    write_slots(6'd0);
    send_request(make_request(tscp_pkg::FUNC_LOOKUP, 32'h0000_0001, 1'b1, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_BEGIN_SESS, 32'h0000_0001, 1'b1, 1'b1));
    send_request(make_request(tscp_pkg::FUNC_END_FRAME, 32'h0000_0001, 1'b1, 1'b1));

    run_phase(6'd4, 0, 0, 180);
    run_phase(6'd32, 72, 0, 200);
    run_phase(6'd1, 0, 72, 120);
    run_phase(6'd0, 11, 11, 60);
    settle();
    hold_request = HOLD_OFF_CYCLES;
    run_phase(6'd63, 0, 0, 150);
    run_phase(6'd33, 0, 72, 110);
    run_phase(6'd6, 11, 11, 150);
    skew_hit_counts();
    run_phase(6'd12, 72, 0, 130);
    settle();

    $display("Ran %0d requests over slot counts 0 to 63 with idling, a long output hold-off",
             tracker.requests);
    $display("and skewed hit counts: %0d hits, %0d loads, %0d evictions, %0d delayed, %0d events",
             tracker.status_seen[tscp_pkg::ST_HIT], tracker.status_seen[tscp_pkg::ST_LOADED],
             tracker.status_seen[tscp_pkg::ST_EVICTED],
             tracker.status_seen[tscp_pkg::ST_DELAYED],
             tracker.status_seen[tscp_pkg::ST_EVENT]);
    if (tracker.mismatches == 0) begin
      $display("PASS texture_slot_cache_policy");
    end else begin
      $display("FAIL texture_slot_cache_policy");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", tracker.awaited_outcomes.size());
    $display("FAIL texture_slot_cache_policy");
    $finish;
  end

endmodule
